@@ rtl/bspq_pkg.sv @@
package bspq_pkg;

   // Fixed payload widths
   localparam int PRIORITY_BITS = 8;
   localparam int TAG_BITS      = 16;
   localparam int SEQ_BITS      = 32;
   localparam int COUNT_BITS    = 5;
   localparam int MODE_BITS     = 2;
   localparam int STATUS_BITS   = 2;

   // Default capacity of the cell chain
   localparam int DEPTH_DEFAULT = 16;

   // Reset value of the entry limit register
   localparam logic [COUNT_BITS-1:0] MAX_ENTRIES_RESET = COUNT_BITS'(16);

   // Operation codes
   localparam logic [MODE_BITS-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DEQUEUE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PEEK    = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_SPARE   = 2'd3;

   // Status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [MODE_BITS-1:0]     mode;
      logic [PRIORITY_BITS-1:0] in_priority;
      logic [TAG_BITS-1:0]      in_tag;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [TAG_BITS-1:0]      out_tag;
      logic [PRIORITY_BITS-1:0] out_priority;
      logic [SEQ_BITS-1:0]      out_sequence;
      logic [COUNT_BITS-1:0]    entry_count;
      logic [SEQ_BITS-1:0]      next_sequence;
   } rsp_payload_type;

   // One stored entry
   typedef struct packed {
      logic [PRIORITY_BITS-1:0] priority_val;
      logic [TAG_BITS-1:0]      tag;
      logic [SEQ_BITS-1:0]      seq;
   } entry_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_cmd_type;

endpackage

@@ rtl/bounded_stable_priority_queue.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  mode, in_priority, in_tag
// rsp_      out        rsp_valid / rsp_ready  status, tag, priority, sequence, counts
// csr_      in         csr_wr_en              max_entries
//
// One item per cycle: the sorted cell chain updates in the transfer cycle and
// the result sits in one output register the cycle after.
// req_ready stays high while the output register is empty or being drained.
// A stall on rsp_ready holds the result and blocks new transfers.
// Synchronous reset empties the queue, clears the push counter and sets the
// limit to 16; cell contents are not cleared.
module bounded_stable_priority_queue #(
   parameter int DEPTH = bspq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bspq_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bspq_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [bspq_pkg::COUNT_BITS-1:0]     csr_wr_data
);

   logic [bspq_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [bspq_pkg::SEQ_BITS-1:0]   seq_ff, seq_in;
   logic [bspq_pkg::COUNT_BITS-1:0] max_entries_ff;
   logic                            rsp_valid_ff;
   bspq_pkg::rsp_payload_type       rsp_ff, rsp_in;

   logic                   req_xfer;
   logic                   is_enqueue;
   logic                   is_dequeue;
   logic                   full;
   logic                   empty;
   bspq_pkg::cell_cmd_type cmd;
   bspq_pkg::entry_type    head;

   logic                   take  [DEPTH];
   bspq_pkg::entry_type    cells [DEPTH];

   // Accept while the output register is free or being drained
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_xfer   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign is_enqueue = (req_payload.mode == bspq_pkg::MODE_ENQUEUE);
   assign is_dequeue = (req_payload.mode == bspq_pkg::MODE_DEQUEUE);
   assign full  = (count_ff >= max_entries_ff) || (32'(count_ff) >= 32'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = cells[0];

   // Broadcast the command to the chain
   always_comb begin
      cmd.insert            = req_xfer && is_enqueue && !full;
      cmd.remove            = req_xfer && is_dequeue && !empty;
      cmd.item.priority_val = req_payload.in_priority;
      cmd.item.tag          = req_payload.in_tag;
      cmd.item.seq          = seq_ff;
   end

   // Sorted chain: cell 0 holds the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                left_take;
      bspq_pkg::entry_type left_data;
      bspq_pkg::entry_type right_data;

      if (i == 0) begin : g_first
         assign left_take = 1'b0;
         assign left_data = cmd.item;
      end else begin : g_mid
         assign left_take = take[i-1];
         assign left_data = cells[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = cells[i+1];
      end

      bspq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (32'(i) < 32'(count_ff)),
         .left_take  (left_take),
         .left_data  (left_data),
         .right_data (right_data),
         .take       (take[i]),
         .data       (cells[i])
      );
   end

   // Next count, counter and result
   always_comb begin
      count_in = count_ff;
      seq_in   = seq_ff;
      rsp_in   = rsp_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
         seq_in   = seq_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
      if (req_xfer) begin
         rsp_in.status       = bspq_pkg::STATUS_OK;
         rsp_in.out_tag      = '0;
         rsp_in.out_priority = '0;
         rsp_in.out_sequence = '0;
         if (is_enqueue) begin
            if (full) begin
               rsp_in.status = bspq_pkg::STATUS_FULL;
            end
         end else if (empty) begin
            rsp_in.status = bspq_pkg::STATUS_EMPTY;
         end else begin
            rsp_in.out_tag      = head.tag;
            rsp_in.out_priority = head.priority_val;
            rsp_in.out_sequence = head.seq;
         end
         rsp_in.entry_count   = count_in;
         rsp_in.next_sequence = seq_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         seq_ff         <= '0;
         max_entries_ff <= bspq_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         seq_ff   <= seq_in;
         if (csr_wr_en) begin
            max_entries_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   // Count never passes the chain length
   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("entry count exceeds chain depth");

   // Counter and count advance whenever an entry is inserted
   assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (seq_ff == $past(seq_ff) + 1'b1) && (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not advance counter and count");

   // Head never ranks below its neighbor
   if (DEPTH > 1) begin : g_order_chk
      assert property (@(posedge clock) disable iff (reset)
         (count_ff >= 2) |-> (cells[0].priority_val >= cells[1].priority_val))
         else $error("chain head out of order");
   end

   // No transfer while a stalled result is held
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_xfer)
      else $error("transfer accepted over stalled result");
`endif

endmodule

@@ rtl/bspq_cell.sv @@
module bspq_cell (
   input  logic                  clock,
   input  bspq_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic                  left_take,
   input  bspq_pkg::entry_type   left_data,
   input  bspq_pkg::entry_type   right_data,
   output logic                  take,
   output bspq_pkg::entry_type   data
);

   bspq_pkg::entry_type data_ff;
   bspq_pkg::entry_type data_in;

   // New item lands at or before this cell: free slot or strictly lower priority
   assign take = !occupied || (data_ff.priority_val < cmd.item.priority_val);
   assign data = data_ff;

   // Insert shifts the tail right, remove shifts everything left
   always_comb begin
      data_in = data_ff;
      if (cmd.insert && take) begin
         data_in = left_take ? left_data : cmd.item;
      end else if (cmd.remove) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
